[rtl/mrrc_pkg.sv]
// Modbus RTU reply checker: shared types, constants and the CRC-16 byte fold.
// Used by mrrc_frame, modbus_rtu_reply_checker_top and mrrc_checker.
`default_nettype none

package mrrc_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam int unsigned EXC_BIT  = 7;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDR_ERR = 2'd1;
  localparam logic [1:0] ST_CRC_ERR  = 2'd2;
  localparam logic [1:0] ST_EXC      = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_FUNC  = 6'b000010,
    PH_DATA  = 6'b000100,
    PH_CRCLO = 6'b001000,
    PH_CRCHI = 6'b010000,
    PH_SKIP  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic [7:0] expected_length;
  } in_item_t;

  typedef struct packed {
    logic       has;
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [7:0] exception_code;
  } result_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/mrrc_frame.sv]
// Frame tracker: phase, running CRC and byte count for one reply frame.
// Depends on mrrc_pkg. Steps once per registered input item.
`default_nettype none

module mrrc_frame (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire mrrc_pkg::in_item_t item,
  input  wire logic [7:0]        slave_address,
  output      mrrc_pkg::result_t res
);
  import mrrc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        exc_r, exc_nxt;
  logic [7:0]  exc_code_r, exc_code_nxt;
  logic [15:0] crc_fold_b;
  logic [7:0]  func_left;
  logic [7:0]  data_left;

  assign crc_fold_b = crc_fold(crc_r, item.rx_byte);
  assign func_left  = item.rx_byte[EXC_BIT] ? 8'd1 : left_r;
  assign data_left  = left_r - 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    crc_nxt      = crc_r;
    left_nxt     = left_r;
    crc_lo_nxt   = crc_lo_r;
    exc_nxt      = exc_r;
    exc_code_nxt = exc_code_r;
    res          = '0;
    if (item.frame_start) begin
      crc_nxt      = crc_fold(CRC_INIT, item.rx_byte);
      left_nxt     = (item.expected_length == 8'd0) ? 8'd0 : item.expected_length - 8'd1;
      crc_lo_nxt   = 8'd0;
      exc_nxt      = 1'b0;
      exc_code_nxt = 8'd0;
      if (item.rx_byte != slave_address) begin
        phase_nxt  = PH_SKIP;
        res.has    = 1'b1;
        res.kind   = KIND_STATUS;
        res.status = ST_ADDR_ERR;
      end else begin
        phase_nxt = PH_FUNC;
      end
    end else begin
      unique case (phase_r)
        PH_FUNC: begin
          crc_nxt       = crc_fold_b;
          exc_nxt       = item.rx_byte[EXC_BIT] | exc_r;
          left_nxt      = func_left;
          phase_nxt     = (func_left == 8'd0) ? PH_CRCLO : PH_DATA;
          res.has       = 1'b1;
          res.kind      = KIND_PAYLOAD;
          res.data_byte = item.rx_byte;
        end
        PH_DATA: begin
          crc_nxt = crc_fold_b;
          if (exc_r) begin
            exc_code_nxt = item.rx_byte;
          end
          left_nxt = data_left;
          if (data_left == 8'd0) begin
            phase_nxt = PH_CRCLO;
          end
          res.has       = 1'b1;
          res.kind      = KIND_PAYLOAD;
          res.data_byte = item.rx_byte;
        end
        PH_CRCLO: begin
          crc_lo_nxt = item.rx_byte;
          phase_nxt  = PH_CRCHI;
        end
        PH_CRCHI: begin
          phase_nxt = PH_IDLE;
          res.has   = 1'b1;
          res.kind  = KIND_STATUS;
          if ({item.rx_byte, crc_lo_r} != crc_r) begin
            res.status = ST_CRC_ERR;
          end else if (exc_r) begin
            res.status         = ST_EXC;
            res.exception_code = exc_code_r;
          end else begin
            res.status = ST_OK;
          end
        end
        PH_IDLE, PH_SKIP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      crc_r      <= CRC_INIT;
      left_r     <= 8'd0;
      crc_lo_r   <= 8'd0;
      exc_r      <= 1'b0;
      exc_code_r <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      crc_r      <= crc_nxt;
      left_r     <= left_nxt;
      crc_lo_r   <= crc_lo_nxt;
      exc_r      <= exc_nxt;
      exc_code_r <= exc_code_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/modbus_rtu_reply_checker_top.sv]
// Modbus RTU reply checker, top level: input register, frame tracker, result register.
// Depends on mrrc_pkg and mrrc_frame.
//
//   channel | ports                          | contents
//   in      | in_tvalid/tready/tdata/tuser   | received byte, frame start, length
//   out     | out_tvalid/tready/tdata/tlast  | forwarded byte or end-of-frame status
//   cfg     | cfg_wr_en/cfg_wr_data          | expected slave address (reset 1)
//
// One item per cycle sustained while the result is not stalled; an accepted item is
// held in the input register, then its result, if any, in the result register.
// The CRC fold for a byte is eight unrolled steps between the input register and the tracker's CRC register.
// rst_n is synchronous; the block accepts items from the first cycle after reset.
// A stalled result holds the pipeline; in_tready drops only while both stages are full.
`default_nettype none

module modbus_rtu_reply_checker_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] rx_byte, [15:8] expected_length
  input  wire logic        in_tuser,   // [0] frame_start
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // [7:0] data_byte, [9:8] status,
                                       // [17:10] exception_code, [23:18] zero
  output      logic        out_tlast,  // result_kind
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);
  import mrrc_pkg::*;

  logic [7:0] slave_address_r;
  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    res;
  logic       out_free;
  logic       advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= 8'd1;
    end else if (cfg_wr_en) begin
      slave_address_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.rx_byte         <= in_tdata[7:0];
      s1_item_r.expected_length <= in_tdata[15:8];
      s1_item_r.frame_start     <= in_tuser;
    end
  end

  mrrc_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .item          (s1_item_r),
    .slave_address (slave_address_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res.has;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.has) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tlast    = out_res_r.kind;
  assign out_tdata    = {6'd0, out_res_r.exception_code, out_res_r.status,
                         out_res_r.data_byte};

endmodule

`default_nettype wire

[rtl/mrrc_checker.sv]
// Port-level checks for modbus_rtu_reply_checker_top, attached by bind.
// Depends on mrrc_pkg for status codes.
`default_nettype none

module mrrc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);
  import mrrc_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[9:8] == ST_OK && out_tdata[17:10] == 8'd0)
    else $error("payload item carries status bits");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:0] == 8'd0
      && (out_tdata[9:8] == ST_EXC || out_tdata[17:10] == 8'd0))
    else $error("status item carries stray data");

endmodule

bind modbus_rtu_reply_checker_top mrrc_checker u_mrrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
